/* design/lrf_pkg.sv */
// ----------------------------------------------------------------------------
// lrf_pkg
// shared constants and types for the lru frame replacer
// ----------------------------------------------------------------------------
`default_nettype none

package lrf_pkg;

   localparam int MAX_FRAMES = 64;
   localparam int FRAME_W    = 6;
   localparam int COUNT_W    = 7;

   localparam logic [1:0] FUNC_VICTIM = 2'd0;
   localparam logic [1:0] FUNC_PIN    = 2'd1;
   localparam logic [1:0] FUNC_UNPIN  = 2'd2;

   localparam logic [COUNT_W-1:0] CAPACITY_RESET = COUNT_W'(MAX_FRAMES);

   typedef struct packed {
      logic               shift_en;
      logic               append_en;
      logic [FRAME_W-1:0] id;
   } lrf_cmd_type;

endpackage

`default_nettype wire

/* design/lrf_cell.sv */
// ----------------------------------------------------------------------------
// lrf_cell
// one list slot: holds a frame id, matches it, shifts toward the old end
// ----------------------------------------------------------------------------
`default_nettype none

module lrf_cell (
   input  wire                          clock,
   input  wire                          reset,
   input  lrf_pkg::lrf_cmd_type         cmd,
   input  wire [lrf_pkg::FRAME_W-1:0]   upper_id,
   input  wire                          upper_valid,
   input  wire                          lower_valid,
   input  wire                          shift_in,
   output logic                         shift_out,
   output logic [lrf_pkg::FRAME_W-1:0]  id,
   output logic                         valid
);

   logic [lrf_pkg::FRAME_W-1:0] id_ff, id_in;
   logic                        valid_ff, valid_in;
   logic                        match;

   assign match     = valid_ff && (id_ff == cmd.id);
   assign shift_out = shift_in || match;
   assign id        = id_ff;
   assign valid     = valid_ff;

   always_comb begin
      priority if (cmd.shift_en && shift_out) begin
         id_in    = upper_id;
         valid_in = upper_valid;
      end else if (cmd.append_en && lower_valid && !valid_ff) begin
         id_in    = cmd.id;
         valid_in = 1'b1;
      end else begin
         id_in    = id_ff;
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      id_ff <= id_in;
   end

endmodule

`default_nettype wire

/* design/lru_frame_replacer.sv */
// ----------------------------------------------------------------------------
// lru_frame_replacer
// age-ordered list of evictable frames kept in a row of shifting cells
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 word
//  req_     in         req_valid / req_ready      func, frame
//  rsp_     out        rsp_valid / rsp_ready      victim_found, victim_frame, occupancy
//  csr_     in         csr_write_enable           capacity
//
//  one word per cycle unless the result is stalled; the result is registered in the cycle after acceptance
//  the cycle is set by the match ripple through all 64 cells
//  reset clears all slot valid flags, the count and the result valid at once
//  a stalled result holds; a new word is taken in the cycle the result leaves
// ----------------------------------------------------------------------------
`default_nettype none

module lru_frame_replacer (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire [1:0]                    req_func,
   input  wire [lrf_pkg::FRAME_W-1:0]   req_frame,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic                         rsp_victim_found,
   output logic [lrf_pkg::FRAME_W-1:0]  rsp_victim_frame,
   output logic [lrf_pkg::COUNT_W-1:0]  rsp_occupancy,
   input  wire                          csr_write_enable,
   input  wire [lrf_pkg::COUNT_W-1:0]   csr_write_data
);

   localparam int N = lrf_pkg::MAX_FRAMES;

   logic [lrf_pkg::COUNT_W-1:0] capacity_ff;
   logic [lrf_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [lrf_pkg::COUNT_W-1:0] limit;
   logic                        rsp_valid_ff;
   logic                        found_ff, found_in;
   logic [lrf_pkg::FRAME_W-1:0] vframe_ff, vframe_in;

   logic [lrf_pkg::FRAME_W-1:0] cell_id    [0:N];
   logic                        cell_valid [0:N];
   logic                        shift      [0:N];

   lrf_pkg::lrf_cmd_type cmd;
   logic accept, is_victim, is_pin, is_unpin, any_match, append;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_victim = accept && (req_func == lrf_pkg::FUNC_VICTIM);
   assign is_pin    = accept && (req_func == lrf_pkg::FUNC_PIN);
   assign is_unpin  = accept && (req_func == lrf_pkg::FUNC_UNPIN);

   assign limit = (capacity_ff > lrf_pkg::COUNT_W'(N)) ? lrf_pkg::COUNT_W'(N) : capacity_ff;

   // match chain starts high for victim so every cell pops
   assign shift[0]      = is_victim;
   assign any_match     = shift[N];
   assign cell_id[N]    = '0;
   assign cell_valid[N] = 1'b0;
   assign append        = is_unpin && !any_match && (count_ff < limit);

   assign cmd.shift_en  = is_victim || is_pin;
   assign cmd.append_en = append;
   assign cmd.id        = req_frame;

   for (genvar i = 0; i < N; i++) begin : g_cell
      lrf_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .upper_id    (cell_id[i+1]),
         .upper_valid (cell_valid[i+1]),
         .lower_valid ((i == 0) ? 1'b1 : cell_valid[(i == 0) ? 0 : i-1]),
         .shift_in    (shift[i]),
         .shift_out   (shift[i+1]),
         .id          (cell_id[i]),
         .valid       (cell_valid[i])
      );
   end

   always_comb begin
      priority if (is_victim && cell_valid[0]) begin
         count_in  = count_ff - lrf_pkg::COUNT_W'(1);
         found_in  = 1'b1;
         vframe_in = cell_id[0];
      end else if (is_pin && any_match) begin
         count_in  = count_ff - lrf_pkg::COUNT_W'(1);
         found_in  = 1'b0;
         vframe_in = '0;
      end else if (append) begin
         count_in  = count_ff + lrf_pkg::COUNT_W'(1);
         found_in  = 1'b0;
         vframe_in = '0;
      end else begin
         count_in  = count_ff;
         found_in  = 1'b0;
         vframe_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= lrf_pkg::CAPACITY_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         found_ff  <= found_in;
         vframe_ff <= vframe_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_victim_found = found_ff;
   assign rsp_victim_frame = vframe_ff;
   assign rsp_occupancy    = count_ff;

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= lrf_pkg::COUNT_W'(N))
      else $error("occupancy beyond slot depth");

   a_head_valid : assert property (@(posedge clock) disable iff (reset)
      cell_valid[0] == (count_ff != '0))
      else $error("oldest slot flag disagrees with occupancy");

   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !accept)
      else $error("word taken while result stalled");

   a_victim_count : assert property (@(posedge clock) disable iff (reset)
      is_victim && cell_valid[0] |=> count_ff == $past(count_ff) - lrf_pkg::COUNT_W'(1))
      else $error("victim pop did not drop occupancy");

   a_found_frame : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_victim_found |-> rsp_victim_frame == '0)
      else $error("frame reported without victim");

endmodule

`default_nettype wire
